// ===== sv/swet_pkg.sv =====
// Package for the sliding window extremum tracker.
// Holds widths, codes, the command and configuration types and a ring helper.
// No dependencies.
`default_nettype none

package swet_pkg;

  // Ring queue depth and derived widths
  localparam int WINDOW_DEPTH = 8;
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int OCC_W        = $clog2(WINDOW_DEPTH + 1);

  // Field widths
  localparam int VALUE_W  = 64;
  localparam int TIME_W   = 64;
  localparam int STATUS_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIFETIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_MAXIMUM  = 1'b1;
  localparam logic [TIME_W-1:0]    LIFETIME_RESET     = TIME_W'(1000000);

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_IDX_W = 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Input opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic {
    CMD_INSERT,
    CMD_CLEAR
  } cmd_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED  = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_CLEAR   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORDER,
    ST_HEAD_DROP,
    ST_REAR_POP,
    ST_APPEND,
    ST_RESULT
  } eng_state_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [VALUE_W-1:0] value;
    logic [TIME_W-1:0]  stamp;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    cmd_t               cmd;
  } cmd_chan_t;

  typedef struct packed {
    logic [TIME_W-1:0] lifetime;
    logic              track_max;
  } cfg_t;

  // Ring position base + off, for base < depth and off <= depth
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [OCC_W-1:0] off);
    logic [OCC_W:0] sum;
    sum = (OCC_W+1)'(base) + {1'b0, off};
    if (sum >= (OCC_W+1)'(WINDOW_DEPTH)) begin
      sum = sum - (OCC_W+1)'(WINDOW_DEPTH);
    end
    return IDX_W'(sum);
  endfunction

endpackage

`default_nettype wire

// ===== sv/swet_ifs.sv =====
// Valid/ready channel interfaces for the sliding window extremum tracker.
// Depends on swet_pkg for field widths.
`default_nettype none

interface swet_req_if;
  import swet_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [VALUE_W-1:0] sample_value;
  logic [TIME_W-1:0]  sample_time;

  modport source(output valid, opcode, sample_value, sample_time, input ready);
  modport sink(input valid, opcode, sample_value, sample_time, output ready);
endinterface

interface swet_rsp_if;
  import swet_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [VALUE_W-1:0]  extremum_value;
  logic [TIME_W-1:0]   extremum_time;
  logic [STATUS_W-1:0] insert_status;

  modport source(output valid, found, extremum_value, extremum_time, insert_status,
                 input ready);
  modport sink(input valid, found, extremum_value, extremum_time, insert_status,
               output ready);
endinterface

`default_nettype wire

// ===== sv/sliding_window_extremum_tracker.sv =====
// Top level of the sliding window extremum tracker.
// Depends on swet_pkg, swet_ifs, swet_cmd_queue and swet_window_engine.
//
// Tracks the minimum or maximum (track_maximum register) of timestamped 64-bit
// samples over a time window of entry_lifetime units, in a monotone ring queue
// of WINDOW_DEPTH entries. Each request transaction (insert or clear) yields
// exactly one response transaction carrying the head entry after the step and
// an insert status. Requests enter a two-deep command queue, so new requests
// are taken while the engine works or while a response waits to be taken.
// The engine walks the queue one entry per cycle: an insert into a non-empty
// queue checks order, drops expired head entries, pops expired or dominated
// rear entries and appends, an insert into an empty queue appends directly,
// an out-of-order insert is ignored and a clear empties the queue, each then
// waiting on the response side. Write configuration only while idle.
`default_nettype none

module sliding_window_extremum_tracker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  swet_req_if.sink                             req,
  swet_rsp_if.source                           rsp,
  input  wire logic                            cfg_wr_en,
  input  wire logic [swet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swet_pkg::CFG_DATA_W-1:0] cfg_data
);
  import swet_pkg::*;

  cfg_t      cfg;
  cmd_chan_t cmd_chan;
  logic      cmd_pop;

  // Configuration registers: write on enable, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lifetime  <= LIFETIME_RESET;
      cfg.track_max <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENTRY_LIFETIME: cfg.lifetime  <= cfg_data[TIME_W-1:0];
        REG_TRACK_MAXIMUM:  cfg.track_max <= cfg_data[0];
        default: begin
          // hold
        end
      endcase
    end
  end

  // Front: accept and classify requests, buffer them
  swet_cmd_queue u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cmd_out (cmd_chan),
    .cmd_pop (cmd_pop)
  );

  // Back: drop expired heads, pop expired or dominated rears, append, report head
  swet_window_engine u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd_in  (cmd_chan),
    .cmd_pop (cmd_pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

// ===== sv/swet_cmd_queue.sv =====
// Front part: accepts request transactions, classifies them and queues them.
// Depends on swet_pkg and swet_req_if.
`default_nettype none

module swet_cmd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  swet_req_if.sink               req,
  output swet_pkg::cmd_chan_t    cmd_out,
  input  wire logic              cmd_pop
);
  import swet_pkg::*;

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_IDX_W-1:0] wr_ptr;
  logic [CMDQ_IDX_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  push;
  logic                  pop;
  cmd_t                  cmd_in;

  assign req.ready = (count != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign push      = req.valid && req.ready;
  assign pop       = cmd_pop && (count != '0);

  // Classify the request
  always_comb begin
    cmd_in.kind  = (req.opcode == OP_CLEAR) ? CMD_CLEAR : CMD_INSERT;
    cmd_in.value = req.sample_value;
    cmd_in.stamp = req.sample_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  assign cmd_out.valid = (count != '0);
  assign cmd_out.cmd   = slots[rd_ptr];

endmodule

`default_nettype wire

// ===== sv/swet_window_engine.sv =====
// Back part: sequencer over the monotone ring queue, entry memory and result register.
// Depends on swet_pkg and swet_rsp_if.
`default_nettype none

module swet_window_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire swet_pkg::cfg_t    cfg,
  input  wire swet_pkg::cmd_chan_t cmd_in,
  output logic                   cmd_pop,
  swet_rsp_if.source             rsp
);
  import swet_pkg::*;

  eng_state_t         state, state_next;
  logic [IDX_W-1:0]   head, head_next;
  logic [OCC_W-1:0]   occ, occ_next;
  status_t            status, status_next;
  cmd_t               cur;

  // Entry memory, two registered read ports with write-through
  logic [VALUE_W-1:0] mem_val  [WINDOW_DEPTH];
  logic [TIME_W-1:0]  mem_time [WINDOW_DEPTH];
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_head_addr;
  logic [IDX_W-1:0]   rd_rear_addr;
  logic [OCC_W-1:0]   rear_off;
  logic [VALUE_W-1:0] hd_val, rr_val;
  logic [TIME_W-1:0]  hd_time, rr_time;

  logic               head_expired;
  logic               rear_expired;
  logic               dominated;
  logic               load_out;

  logic                o_valid;
  logic                o_found;
  logic [VALUE_W-1:0]  o_value;
  logic [TIME_W-1:0]   o_time;
  logic [STATUS_W-1:0] o_status;

  assign head_expired = (cur.stamp - hd_time) > cfg.lifetime;
  assign rear_expired = (cur.stamp - rr_time) > cfg.lifetime;
  assign dominated    = cfg.track_max ? (cur.value >= rr_val) : (cur.value <= rr_val);

  // Read addresses follow the next head and occupancy, so data is valid every cycle
  assign rear_off     = (occ_next == '0) ? '0 : occ_next - 1'b1;
  assign rd_head_addr = head_next;
  assign rd_rear_addr = ring_add(head_next, rear_off);
  assign wr_addr      = ring_add(head, occ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      head   <= '0;
      occ    <= '0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      occ    <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    if (cmd_pop) begin
      cur <= cmd_in.cmd;
    end
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    occ_next    = occ;
    status_next = status;
    cmd_pop     = 1'b0;
    wr_en       = 1'b0;
    load_out    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_in.valid) begin
          cmd_pop = 1'b1;
          if (cmd_in.cmd.kind == CMD_CLEAR) begin
            head_next   = '0;
            occ_next    = '0;
            status_next = STAT_CLEAR;
            state_next  = ST_RESULT;
          end else if (occ == '0) begin
            state_next = ST_APPEND;
          end else begin
            state_next = ST_ORDER;
          end
        end
      end
      ST_ORDER: begin
        if (cur.stamp < rr_time) begin
          status_next = STAT_IGNORED;
          state_next  = ST_RESULT;
        end else begin
          state_next = ST_HEAD_DROP;
        end
      end
      ST_HEAD_DROP: begin
        // Drop one expired head entry a cycle
        if ((occ != '0) && head_expired) begin
          head_next = ring_add(head, OCC_W'(1));
          occ_next  = occ - 1'b1;
        end else begin
          state_next = ST_REAR_POP;
        end
      end
      ST_REAR_POP: begin
        // Pop one expired or dominated rear entry a cycle
        if ((occ != '0) && (rear_expired || dominated)) begin
          occ_next = occ - 1'b1;
        end else begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (occ < OCC_W'(WINDOW_DEPTH)) begin
          wr_en       = 1'b1;
          occ_next    = occ + 1'b1;
          status_next = STAT_STORED;
        end else begin
          status_next = STAT_FULL;
        end
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!o_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_val[wr_addr]  <= cur.value;
      mem_time[wr_addr] <= cur.stamp;
    end
    if (wr_en && (wr_addr == rd_head_addr)) begin
      hd_val  <= cur.value;
      hd_time <= cur.stamp;
    end else begin
      hd_val  <= mem_val[rd_head_addr];
      hd_time <= mem_time[rd_head_addr];
    end
    if (wr_en && (wr_addr == rd_rear_addr)) begin
      rr_val  <= cur.value;
      rr_time <= cur.stamp;
    end else begin
      rr_val  <= mem_val[rd_rear_addr];
      rr_time <= mem_time[rd_rear_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_out) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_found  <= (occ != '0);
      o_value  <= (occ != '0) ? hd_val : '0;
      o_time   <= (occ != '0) ? hd_time : '0;
      o_status <= status;
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.found          = o_found;
  assign rsp.extremum_value = o_value;
  assign rsp.extremum_time  = o_time;
  assign rsp.insert_status  = o_status;

endmodule

`default_nettype wire
